// ===== src/msb_first_bit_packer_unit_macros.svh =====
// Assertion macros for the checker file of the bit packer.
// No dependencies; included by bare file name.
`ifndef MSB_FIRST_BIT_PACKER_UNIT_MACROS_SVH
`define MSB_FIRST_BIT_PACKER_UNIT_MACROS_SVH

// Clocked property, switched off while reset is applied.
`define BPK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that is also checked during reset.
`define BPK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== src/bpk_pkg.sv =====
// Package for the MSB-first bit packer: field widths, defaults, item codes.
// No dependencies; used by every module of the block but bpk_fifo.
`default_nettype none

package bpk_pkg;

    localparam int VALUE_W         = 32;
    localparam int COUNT_W         = 6;
    localparam int BYTE_W          = 8;
    localparam int MAX_BITS_DEF    = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic
    {
        REQ_PUT   = 1'b0,
        REQ_ALIGN = 1'b1
    } req_t;

endpackage

`default_nettype wire

// ===== src/bpk_fifo.sv =====
// Small register queue between the front and back parts of the bit packer.
// Depends on nothing but its parameters.
`default_nettype none

module bpk_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  wire logic [W-1:0] wr_data,
    output logic              wr_full,
    input  wire logic         rd_en,
    output logic [W-1:0]      rd_data,
    output logic              rd_valid
);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_full  = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !wr_full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/bpk_front.sv =====
// Front part of the bit packer: takes put and align transactions, merges them
// with the partial byte and queues the completed bytes. Uses bpk_pkg.
`default_nettype none

module bpk_front #(
    parameter int MAX_BITS = bpk_pkg::MAX_BITS_DEF,
    localparam int ACC_W  = MAX_BITS + 7,
    localparam int NBYTES = (MAX_BITS + 7) / 8,
    localparam int WORD_W = NBYTES * 8,
    localparam int NB_W   = $clog2(NBYTES + 1),
    localparam int TOT_W  = $clog2(ACC_W + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic                          req_type,
    input  wire logic [bpk_pkg::VALUE_W-1:0]   bit_value,
    input  wire logic [bpk_pkg::COUNT_W-1:0]   bit_count,
    input  wire logic                          q_full,
    output logic                               q_push,
    output logic [WORD_W-1:0]                  q_word,
    output logic [NB_W-1:0]                    q_nb
);

    import bpk_pkg::*;

    logic [BYTE_W-1:0]  partial_reg;
    logic [BYTE_W-1:0]  partial_next;
    logic [2:0]         filled_reg;
    logic [2:0]         filled_next;
    logic               accept;
    logic [COUNT_W-1:0] cnt;
    logic [ACC_W-1:0]   mask;
    logic [ACC_W-1:0]   joined;
    logic [TOT_W-1:0]   total;
    logic [2:0]         rem;
    logic [BYTE_W-1:0]  align_byte;
    logic [NB_W-1:0]    nb;

    assign accept = push && !q_full;
    assign q_push = accept && (nb != '0);
    assign q_nb   = nb;

    always_comb
    begin
        cnt = bit_count;
        if (int'(bit_count) > MAX_BITS)
        begin
            cnt = COUNT_W'(MAX_BITS);
        end
        mask   = ~({ACC_W{1'b1}} << cnt);
        joined = (ACC_W'(partial_reg) << cnt) | (ACC_W'(bit_value) & mask);
        total  = TOT_W'(filled_reg) + TOT_W'(cnt);
        rem    = total[2:0];
        // pad to the boundary: shift left by 8 - filled
        align_byte = partial_reg << (3'd0 - filled_reg);

        if (req_t'(req_type) == REQ_ALIGN)
        begin
            nb           = (filled_reg != '0) ? NB_W'(1) : '0;
            q_word       = WORD_W'(align_byte) << (WORD_W - BYTE_W);
            partial_next = '0;
            filled_next  = '0;
        end
        else
        begin
            nb = NB_W'(total >> 3);
            // complete bytes, first one moved to the top of the word
            q_word       = WORD_W'(joined >> rem) << {NB_W'(NBYTES) - nb, 3'b000};
            partial_next = BYTE_W'(joined) & ~(8'hFF << rem);
            filled_next  = rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            filled_reg  <= '0;
        end
        else if (accept)
        begin
            partial_reg <= partial_next;
            filled_reg  <= filled_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/bpk_back.sv =====
// Back part of the bit packer: unloads one queued run and hands out its bytes
// one per transaction, marking the last. Uses bpk_pkg.
`default_nettype none

module bpk_back #(
    parameter int MAX_BITS = bpk_pkg::MAX_BITS_DEF,
    localparam int NBYTES = (MAX_BITS + 7) / 8,
    localparam int WORD_W = NBYTES * 8,
    localparam int NB_W   = $clog2(NBYTES + 1)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    input  wire logic [WORD_W-1:0]          q_word,
    input  wire logic [NB_W-1:0]            q_nb,
    output logic                            q_pop,
    input  wire logic                       pop,
    output logic                            empty,
    output logic [bpk_pkg::BYTE_W-1:0]      out_byte,
    output logic                            last_of_run
);

    import bpk_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [NB_W-1:0]   left_reg;
    logic [NB_W-1:0]   left_next;
    logic              take;

    assign empty       = !busy_reg;
    assign out_byte    = word_reg[WORD_W-1 -: BYTE_W];
    assign last_of_run = (left_reg == NB_W'(1));
    assign take        = pop && busy_reg;
    // refill straight after the last byte of a run goes out
    assign q_pop       = q_valid && (!busy_reg || (take && last_of_run));

    always_comb
    begin
        busy_next = busy_reg;
        word_next = word_reg;
        left_next = left_reg;
        if (q_pop)
        begin
            busy_next = 1'b1;
            word_next = q_word;
            left_next = q_nb;
        end
        else if (take)
        begin
            if (last_of_run)
            begin
                busy_next = 1'b0;
            end
            word_next = word_reg << BYTE_W;
            left_next = left_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

`default_nettype wire

// ===== src/msb_first_bit_packer_unit.sv =====
// MSB-first bit packer. A put transaction appends the low bit_count bits of
// bit_value (count saturated to MAX_BITS), an align transaction zero-pads to the
// next byte boundary; each completed byte comes out as one result transaction,
// the last byte of each item flagged by last_of_run. One item is accepted per
// cycle while full is low; the output side gives one byte per cycle while pop is
// high, so an item that completes k bytes (up to (MAX_BITS+7)/8) holds the output
// port for its k bytes and the QUEUE_DEPTH-entry run queue between the parts soaks
// up bursts. With the output side idle, an accepted item's bytes are written
// into the run queue and then loaded into the back part's output register.
// Depends on bpk_pkg, bpk_fifo, bpk_front and bpk_back.
`default_nettype none

module msb_first_bit_packer_unit #(
    parameter int MAX_BITS    = bpk_pkg::MAX_BITS_DEF,
    parameter int QUEUE_DEPTH = bpk_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          req_type,
    input  wire logic [bpk_pkg::VALUE_W-1:0]   bit_value,
    input  wire logic [bpk_pkg::COUNT_W-1:0]   bit_count,
    input  wire logic                          pop,
    output logic                               empty,
    output logic [bpk_pkg::BYTE_W-1:0]         out_byte,
    output logic                               last_of_run
);

    import bpk_pkg::*;

    localparam int NBYTES = (MAX_BITS + 7) / 8;
    localparam int WORD_W = NBYTES * 8;
    localparam int NB_W   = $clog2(NBYTES + 1);

    logic              q_push;
    logic              q_full;
    logic [WORD_W-1:0] q_in_word;
    logic [NB_W-1:0]   q_in_nb;
    logic              q_pop;
    logic              q_valid;
    logic [WORD_W-1:0] q_out_word;
    logic [NB_W-1:0]   q_out_nb;

    assign full = q_full;

    bpk_front #(
        .MAX_BITS (MAX_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .req_type  (req_type),
        .bit_value (bit_value),
        .bit_count (bit_count),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_word    (q_in_word),
        .q_nb      (q_in_nb)
    );

    bpk_fifo #(
        .W     (WORD_W + NB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  ({q_in_word, q_in_nb}),
        .wr_full  (q_full),
        .rd_en    (q_pop),
        .rd_data  ({q_out_word, q_out_nb}),
        .rd_valid (q_valid)
    );

    bpk_back #(
        .MAX_BITS (MAX_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_word      (q_out_word),
        .q_nb        (q_out_nb),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

// ===== src/bpk_checker.sv =====
// Port-level checks for the bit packer, bound to the top level.
// Depends on bpk_pkg and msb_first_bit_packer_unit_macros.svh.
`default_nettype none
`include "msb_first_bit_packer_unit_macros.svh"

module bpk_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic                          full,
    input  wire logic                          req_type,
    input  wire logic [bpk_pkg::VALUE_W-1:0]   bit_value,
    input  wire logic [bpk_pkg::COUNT_W-1:0]   bit_count,
    input  wire logic                          pop,
    input  wire logic                          empty,
    input  wire logic [bpk_pkg::BYTE_W-1:0]    out_byte,
    input  wire logic                          last_of_run
);

    import bpk_pkg::*;

    logic put_byte;

    // a put of at least one full byte always completes a byte
    assign put_byte = push && !full && (req_t'(req_type) == REQ_PUT)
                      && (bit_count >= COUNT_W'(BYTE_W)) && (bit_value == bit_value);

    `BPK_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> empty && !full, "not idle in reset")
    `BPK_ASSERT(a_hold, clk, rst_n, !empty && !pop |=> !empty && $stable(out_byte) && $stable(last_of_run), "waiting result changed")
    `BPK_ASSERT(a_run_rest, clk, rst_n, pop && !empty && !last_of_run |=> !empty, "run cut short")
    `BPK_ASSERT(a_put_out, clk, rst_n, put_byte |-> ##2 !empty, "completed byte not shown")

endmodule

bind msb_first_bit_packer_unit bpk_checker u_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for msb_first_bit_packer_unit: directed and random code
// transactions, an in-bench packer model and a byte-by-byte result check.
// Depends on bpk_pkg and the msb_first_bit_packer_unit RTL.
`timescale 1ns / 100ps

module tb_top;

    import bpk_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int PACK_LIMIT  = MAX_BITS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_CODES  = 300;
    localparam int TAIL_CYCLES = 60;
    localparam int MAX_SHOWN   = 10;

    typedef struct {
        req_t              kind;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        bit                drain;
    } code_item_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } packed_byte_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b1;
    logic                push = 1'b0;
    logic                req_type = REQ_PUT;
    logic [VALUE_W-1:0]  bit_value = '0;
    logic [COUNT_W-1:0]  bit_count = '0;
    logic                pop = 1'b0;
    logic                full;
    logic                empty;
    logic [BYTE_W-1:0]   out_byte;
    logic                last_of_run;

    code_item_t   code_q[$];
    packed_byte_t byte_q[$];

    // model of the packer's partial byte
    logic [BYTE_W-1:0] acc_bits = '0;
    int                acc_fill = 0;

    int miss_cnt  = 0;
    int send_gap  = 0;
    int take_gap  = 0;
    int idle_cyc  = 0;

    msb_first_bit_packer_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .bit_value  (bit_value),
        .bit_count  (bit_count),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .last_of_run(last_of_run)
    );

    always #CLK_HALF clk = ~clk;

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void add_code(req_t kind, logic [VALUE_W-1:0] value,
                                     logic [COUNT_W-1:0] count, bit drain);
        code_item_t c;
        c.kind  = kind;
        c.value = value;
        c.count = count;
        c.drain = drain;
        code_q.push_back(c);
    endfunction

    // Works out the bytes completed by one accepted code transaction
    function automatic void pack_code(req_t kind, logic [VALUE_W-1:0] value,
                                      logic [COUNT_W-1:0] count);
        packed_byte_t done[$];
        packed_byte_t b;
        int n;
        n = (count > PACK_LIMIT) ? PACK_LIMIT : int'(count);
        if (kind == REQ_PUT)
        begin
            for (int k = n - 1; k >= 0; k--)
            begin
                acc_bits = {acc_bits[BYTE_W-2:0], value[k]};
                acc_fill++;
                if (acc_fill == BYTE_W)
                begin
                    b.data = acc_bits;
                    b.last = 1'b0;
                    done.push_back(b);
                    acc_bits = '0;
                    acc_fill = 0;
                end
            end
        end
        else if (acc_fill != 0)
        begin
            b.data = acc_bits << (BYTE_W - acc_fill);
            b.last = 1'b0;
            done.push_back(b);
            acc_bits = '0;
            acc_fill = 0;
        end
        for (int k = 0; k < done.size(); k++)
        begin
            b = done[k];
            b.last = (k == done.size() - 1);
            byte_q.push_back(b);
        end
    endfunction

    function automatic void flag_miss(string what, logic [31:0] want, logic [31:0] got);
        miss_cnt++;
        if (miss_cnt <= MAX_SHOWN)
            $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
    endfunction

    // Sender
    always @(posedge clk or negedge rst_n)
    begin : p_send
        bit         sent;
        code_item_t nxt;
        if (!rst_n)
        begin
            push      <= 1'b0;
            req_type  <= REQ_PUT;
            bit_value <= '0;
            bit_count <= '0;
            send_gap  = 0;
        end
        else
        begin
            sent = push && !full;
            if (sent)
                pack_code(req_t'(req_type), bit_value, bit_count);
            if (push && !sent)
            begin
                // hold the transaction until it is taken
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (code_q.size() != 0 && !(code_q[0].drain && byte_q.size() != 0))
            begin
                nxt = code_q.pop_front();
                push      <= 1'b1;
                req_type  <= nxt.kind;
                bit_value <= nxt.value;
                bit_count <= nxt.count;
                send_gap  = pick_gap();
            end
            else
                push <= 1'b0;
        end
    end

    // Receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : p_check
        packed_byte_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
            take_gap = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (byte_q.size() == 0)
                    flag_miss("unexpected byte", '0, 32'(out_byte));
                else
                begin
                    want = byte_q.pop_front();
                    if (out_byte !== want.data)
                        flag_miss("out_byte", 32'(want.data), 32'(out_byte));
                    if (last_of_run !== want.last)
                        flag_miss("last_of_run", 32'(want.last), 32'(last_of_run));
                end
                take_gap = pick_gap();
            end
            if (take_gap > 0)
            begin
                take_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc == STALL_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        int r;
        logic [COUNT_W-1:0] cnt;

        // directed part
        add_code(REQ_ALIGN, 32'h0000_0000, 6'd0,  1'b0);  // align at reset, on boundary
        add_code(REQ_PUT,   32'hffff_ffff, 6'd0,  1'b0);  // zero count
        add_code(REQ_PUT,   32'hffff_ffff, 6'd1,  1'b0);
        add_code(REQ_ALIGN, 32'hdead_beef, 6'd63, 1'b0);  // operands ignored
        add_code(REQ_PUT,   32'hffff_ffff, 6'd32, 1'b0);
        add_code(REQ_PUT,   32'h0000_0000, 6'd32, 1'b0);
        add_code(REQ_PUT,   32'hffff_fffd, 6'd3,  1'b0);  // garbage above count
        add_code(REQ_PUT,   32'h8000_0001, 6'd32, 1'b0);  // four bytes from a partial byte
        add_code(REQ_PUT,   32'ha5a5_a5a5, 6'd63, 1'b0);  // saturates
        add_code(REQ_PUT,   32'h5a5a_5a5a, 6'd33, 1'b0);
        add_code(REQ_PUT,   32'h0000_00ff, 6'd8,  1'b0);
        add_code(REQ_PUT,   32'h0000_0000, 6'd0,  1'b0);
        add_code(REQ_PUT,   32'h0000_007f, 6'd7,  1'b0);
        add_code(REQ_ALIGN, 32'hffff_ffff, 6'd32, 1'b0);
        add_code(REQ_ALIGN, 32'h0000_0000, 6'd0,  1'b0);  // second align on boundary
        add_code(REQ_PUT,   32'h1234_5678, 6'd40, 1'b0);
        add_code(REQ_PUT,   32'h0000_0001, 6'd1,  1'b0);
        add_code(REQ_PUT,   32'h7fff_ffff, 6'd31, 1'b0);
        add_code(REQ_PUT,   32'hffff_ffff, 6'd16, 1'b0);
        add_code(REQ_ALIGN, 32'h0000_0000, 6'd0,  1'b0);

        // random part; every so often the sender waits for the output to drain
        for (int k = 0; k < RAND_CODES; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                add_code(REQ_ALIGN, $urandom(), COUNT_W'($urandom_range(0, 63)),
                         (k % 60) == 0);
            else
            begin
                if (r < 15)
                    cnt = '0;
                else if (r < 18)
                    cnt = COUNT_W'($urandom_range(PACK_LIMIT + 1, 63));
                else if (r < 26)
                    cnt = COUNT_W'(PACK_LIMIT);
                else
                    cnt = COUNT_W'($urandom_range(1, 16));
                add_code(REQ_PUT, $urandom(), cnt, (k % 60) == 0);
            end
        end

        // a real falling edge, so the asynchronous resets fire before the first clock
        #1 rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (code_q.size() != 0 || push)
            @(posedge clk);
        while (byte_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (miss_cnt == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
